[sv/ivv_pkg.sv]
// Shared types and character constants for the IPv6 text address validator.
package ivv_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_OPEN   = 8'h5B;
	localparam logic [7:0] CH_CLOSE  = 8'h5D;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;

	localparam logic [2:0] MAX_COLONS   = 3'd7;
	localparam logic [2:0] TAIL_COLONS  = 3'd6;
	localparam logic [1:0] MAX_PERIODS  = 2'd3;
	localparam logic [2:0] MAX_WORD_LEN = 3'd4;
	localparam logic [2:0] MAX_POSITION = 3'd4;
	localparam logic [9:0] MAX_OCTET    = 10'd255;

	typedef enum logic [2:0] {
		CC_OTHER,
		CC_OPEN,
		CC_CLOSE,
		CC_PERIOD,
		CC_COLON,
		CC_DIGIT,
		CC_ALPHA
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
		logic        is_last;
	} ivv_item_t;

endpackage

[sv/ivv_front.sv]
// Front end: classifies each incoming character for the checking engine.
module ivv_front (
	input  logic              [7:0] char_code,
	input  logic                    is_last,
	output ivv_pkg::ivv_item_t      item
);
	import ivv_pkg::*;

	always_comb begin
		item.is_last = is_last;
		item.digit   = 4'd0;
		unique case (char_code) inside
			CH_OPEN:   item.cls = CC_OPEN;
			CH_CLOSE:  item.cls = CC_CLOSE;
			CH_PERIOD: item.cls = CC_PERIOD;
			CH_COLON:  item.cls = CC_COLON;
			[CH_ZERO:CH_NINE]: begin
				item.cls   = CC_DIGIT;
				item.digit = char_code[3:0];
			end
			[CH_UP_A:CH_UP_F], [CH_LOW_A:CH_LOW_F]: item.cls = CC_ALPHA;
			default:   item.cls = CC_OTHER;
		endcase
	end

endmodule

[sv/ivv_queue.sv]
// Short queue of classified characters between the front end and the engine.
module ivv_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  ivv_pkg::ivv_item_t      push_item,
	output logic                    full,
	input  logic                    pop,
	output logic                    head_valid,
	output ivv_pkg::ivv_item_t      head_item
);
	import ivv_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ivv_item_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not follow a write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");

endmodule

[sv/ivv_back.sv]
// Checking engine: applies the address rules per character and registers the verdict.
module ivv_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  ivv_pkg::ivv_item_t      head_item,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    address_valid,
	output logic                    bracketed
);
	import ivv_pkg::*;

	logic        failed_q, failed_n;
	logic        dcs_q, dcs_n;
	logic [2:0]  colon_cnt_q, colon_cnt_n;
	logic [1:0]  period_cnt_q, period_cnt_n;
	logic [2:0]  word_len_q, word_len_n;
	logic        all_dig_q, all_dig_n;
	logic [9:0]  word_val_q, word_val_n;
	logic [2:0]  pos_q, pos_n;
	char_class_t head_q [3];
	char_class_t h0, h1, h2;
	char_class_t recent0_q, recent1_q;
	char_class_t cls;
	char_class_t end1, end2;
	char_class_t at_off0, at_off1;
	logic        off;
	logic        bad;
	logic        br;
	logic [13:0] val_x10;
	logic        out_valid_q;
	logic        out_free;
	logic        take;

	function automatic logic ipv4_part(input logic [2:0] len, input logic all_dig,
			input logic [9:0] val);
		ipv4_part = (len >= 3'd1) && (len <= 3'd3) && all_dig && (val <= MAX_OCTET);
	endfunction

	assign cls      = head_item.cls;
	assign out_free = !out_valid_q || out_ready;
	assign pop      = head_valid && (!head_item.is_last || out_free);
	assign take     = pop;
	assign out_valid = out_valid_q;
	assign val_x10  = {1'b0, word_val_q, 3'b000} + {3'b000, word_val_q, 1'b0};

	always_comb begin
		h0 = (pos_q == 3'd0) ? cls : head_q[0];
		h1 = (pos_q == 3'd1) ? cls : head_q[1];
		h2 = (pos_q == 3'd2) ? cls : head_q[2];
		off = (h0 == CC_OPEN);
		at_off0 = off ? h1 : h0;
		at_off1 = off ? h2 : h1;

		failed_n     = failed_q;
		dcs_n        = dcs_q;
		colon_cnt_n  = colon_cnt_q;
		period_cnt_n = period_cnt_q;
		word_len_n   = word_len_q;
		all_dig_n    = all_dig_q;
		word_val_n   = word_val_q;

		case (cls)
			CC_OPEN: begin
				if (pos_q != 3'd0) failed_n = 1'b1;
			end
			CC_CLOSE: begin
				if (!head_item.is_last || pos_q == 3'd0 || h0 != CC_OPEN) failed_n = 1'b1;
			end
			CC_PERIOD: begin
				if (period_cnt_q >= MAX_PERIODS) failed_n = 1'b1;
				else period_cnt_n = period_cnt_q + 2'd1;
				if (!ipv4_part(word_len_q, all_dig_q, word_val_q)) failed_n = 1'b1;
				if (colon_cnt_q != TAIL_COLONS && !dcs_q) failed_n = 1'b1;
				if (colon_cnt_q == MAX_COLONS && at_off0 != CC_COLON && at_off1 != CC_COLON)
					failed_n = 1'b1;
				word_len_n = 3'd0;
				all_dig_n  = 1'b1;
				word_val_n = 10'd0;
			end
			CC_COLON: begin
				if (colon_cnt_q >= MAX_COLONS) failed_n = 1'b1;
				else colon_cnt_n = colon_cnt_q + 3'd1;
				if (period_cnt_q != 2'd0) failed_n = 1'b1;
				if (pos_q != 3'd0 && recent0_q == CC_COLON) begin
					if (dcs_q) failed_n = 1'b1;
					dcs_n = 1'b1;
				end
				word_len_n = 3'd0;
				all_dig_n  = 1'b1;
				word_val_n = 10'd0;
			end
			default: begin
				if (word_len_q >= MAX_WORD_LEN || cls == CC_OTHER) begin
					failed_n = 1'b1;
				end else begin
					word_len_n = word_len_q + 3'd1;
					if (cls == CC_DIGIT) begin
						if (word_len_q <= 3'd2) word_val_n = val_x10[9:0] + 10'(head_item.digit);
					end else begin
						all_dig_n = 1'b0;
					end
				end
			end
		endcase

		pos_n = (pos_q < MAX_POSITION) ? pos_q + 3'd1 : pos_q;

		br  = (h0 == CC_OPEN);
		bad = failed_n;
		if (pos_n < 3'd2) bad = 1'b1;
		if (br) begin
			if (cls != CC_CLOSE || pos_n < 3'd4) bad = 1'b1;
			else if (h1 == CC_COLON && h2 != CC_COLON) bad = 1'b1;
			end1 = recent0_q;
			end2 = recent1_q;
		end else begin
			end1 = cls;
			end2 = recent0_q;
		end
		if (period_cnt_n != 2'd0) begin
			if (period_cnt_n != MAX_PERIODS || !ipv4_part(word_len_n, all_dig_n, word_val_n))
				bad = 1'b1;
		end else begin
			if (colon_cnt_n != MAX_COLONS && !dcs_n) bad = 1'b1;
			if (word_len_n == 3'd0 && end1 != CC_COLON && end2 != CC_COLON) bad = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q     <= 1'b0;
			dcs_q        <= 1'b0;
			colon_cnt_q  <= 3'd0;
			period_cnt_q <= 2'd0;
			word_len_q   <= 3'd0;
			all_dig_q    <= 1'b1;
			word_val_q   <= 10'd0;
			pos_q        <= 3'd0;
			head_q[0]    <= CC_OTHER;
			head_q[1]    <= CC_OTHER;
			head_q[2]    <= CC_OTHER;
			recent0_q    <= CC_OTHER;
			recent1_q    <= CC_OTHER;
			out_valid_q  <= 1'b0;
		end else begin
			if (take && head_item.is_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (head_item.is_last) begin
					failed_q     <= 1'b0;
					dcs_q        <= 1'b0;
					colon_cnt_q  <= 3'd0;
					period_cnt_q <= 2'd0;
					word_len_q   <= 3'd0;
					all_dig_q    <= 1'b1;
					word_val_q   <= 10'd0;
					pos_q        <= 3'd0;
					head_q[0]    <= CC_OTHER;
					head_q[1]    <= CC_OTHER;
					head_q[2]    <= CC_OTHER;
					recent0_q    <= CC_OTHER;
					recent1_q    <= CC_OTHER;
				end else begin
					failed_q     <= failed_n;
					dcs_q        <= dcs_n;
					colon_cnt_q  <= colon_cnt_n;
					period_cnt_q <= period_cnt_n;
					word_len_q   <= word_len_n;
					all_dig_q    <= all_dig_n;
					word_val_q   <= word_val_n;
					pos_q        <= pos_n;
					head_q[0]    <= h0;
					head_q[1]    <= h1;
					head_q[2]    <= h2;
					recent1_q    <= recent0_q;
					recent0_q    <= cls;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && head_item.is_last) begin
			address_valid <= !bad;
			bracketed     <= br;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(word_len_q <= MAX_WORD_LEN) && (pos_q <= MAX_POSITION))
		else $error("word length or character position out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		word_val_q <= 10'd999)
		else $error("word decimal value beyond three digits");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && head_item.is_last) |=> (out_valid_q && pos_q == 3'd0 && !failed_q))
		else $error("final character did not yield a result and clear the state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(take && head_item.is_last))
		else $error("result overwritten while still pending");

endmodule

[sv/ipv6_text_address_validator_unit.sv]
// Top level of the IPv6 text address validator.
// A result passes through the queue and then the result register after its final
// character is accepted; the engine updates its state as each character is taken.
// Throughput: one character per cycle unless the queue fills or the result port stalls.
// A four-entry queue decouples input acceptance from a stalled result port.
// Reset is asynchronous and active low, clearing the queue, engine state and result flag.
module ipv6_text_address_validator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       address_valid,
	output logic       bracketed
);
	import ivv_pkg::*;

	ivv_item_t front_item;
	ivv_item_t head_item;
	logic      full;
	logic      head_valid;
	logic      pop;

	assign in_ready = !full;

	ivv_front u_front (
		.char_code (char_code),
		.is_last   (is_last),
		.item      (front_item)
	);

	ivv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid),
		.push_item  (front_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	ivv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.address_valid (address_valid),
		.bracketed     (bracketed)
	);

endmodule
